// File: rtl/core/secw_pkg.sv
// types and constants shared by the stroke edge clip walker
// no dependencies
package secw_pkg;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_THRESH = 2'd1,
    MODE_RISING = 2'd2,
    MODE_SPARE  = 2'd3
  } clip_mode_e;

  localparam int unsigned StepLimit = 128;
  localparam int unsigned Frac      = 14;
  localparam logic [35:0] EdgeLimit = 36'd10 << 28;

  typedef struct packed {
    logic        op;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [7:0]  pixel_value;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic signed [15:0] dir_x_step;
    logic signed [15:0] dir_y_step;
    logic [15:0] stroke_length;
  } in_item_t;

  typedef struct packed {
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture query, seed walk 0
    logic seed;      // seed pixel data present, init last sample
    logic step_calc; // compute next position and bound checks
    logic rd_corner; // issue corner read (index in corner)
    logic [1:0] corner;
    logic lat_corner; // latch read data of previous corner
    logic mix1;      // horizontal mix
    logic mix2;      // vertical mix
    logic accept;    // commit step
    logic save_fwd;  // store forward endpoint, restart backward
    logic save_bwd;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic stop_geom;
    logic stop_edge;
    logic limit;
  } sts_t;

endpackage

// File: rtl/core/secw_datapath.sv
// datapath of the stroke edge clip walker: edge map memory, walk position,
// bilinear sample and stop tests; uses secw_pkg
module secw_datapath #(
  parameter int unsigned MAP_WIDTH  = 256,
  parameter int unsigned MAP_HEIGHT = 256
) (
  input  logic                clk_i,
  input  secw_pkg::in_item_t  item_i,
  input  logic                wr_i,
  input  logic [8:0]          bw_i,
  input  logic [8:0]          bh_i,
  input  logic [1:0]          mode_i,
  input  secw_pkg::ctl_t      ctl_i,
  output secw_pkg::sts_t      sts_o,
  output secw_pkg::out_item_t res_o
);
  import secw_pkg::*;

  localparam int unsigned XW = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
  localparam int unsigned YW = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
  localparam int unsigned Depth = 2 ** (XW + YW);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_q;

  // query registers
  logic signed [23:0] cx_q, cy_q, dx_q, dy_q;
  logic [41:0] hsq_q;
  logic signed [23:0] tx_q, ty_q, ax_q, ay_q;
  logic signed [23:0] ddx_q, ddy_q;
  logic [7:0] k_q;
  logic [35:0] last_q;
  logic [7:0] seed_q;
  logic [7:0] p_q [4];
  logic [21:0] top_q, bot_q;
  logic [35:0] smp_q;
  logic geom_q;

  // effective bounds
  function automatic logic [8:0] eff(input logic [8:0] r, input int unsigned m);
    logic [8:0] b;
    b = r;
    if (m < 256 && b > 9'(m)) b = 9'(m);
    if (b > 9'd256) b = 9'd256;
    if (b == 9'd0) b = 9'd1;
    return b;
  endfunction

  logic [8:0] bw, bh;
  assign bw = eff(bw_i, MAP_WIDTH);
  assign bh = eff(bh_i, MAP_HEIGHT);

  // pixel address with clamp to map
  function automatic logic [XW+YW-1:0] addr(input logic [9:0] x, input logic [9:0] y);
    logic [9:0] xc, yc;
    xc = (x >= 10'(MAP_WIDTH))  ? 10'(MAP_WIDTH - 1)  : x;
    yc = (y >= 10'(MAP_HEIGHT)) ? 10'(MAP_HEIGHT - 1) : y;
    return {yc[YW-1:0], xc[XW-1:0]};
  endfunction

  logic signed [23:0] cxn, cyn;
  logic [20:0] half;
  assign cxn  = 24'({item_i.center_x, 6'b0});
  assign cyn  = 24'({item_i.center_y, 6'b0});
  assign half = {item_i.stroke_length, 5'b0};

  // the seed pixel is read in the load cycle, from the incoming center
  logic signed [23:0] csx, csy;
  assign csx = ctl_i.load ? cxn : cx_q;
  assign csy = ctl_i.load ? cyn : cy_q;

  logic [9:0] x0, y0, x1, y1, cpx, cpy;
  logic [13:0] fx, fy;
  assign x0 = {2'b0, tx_q[21:14]};
  assign y0 = {2'b0, ty_q[21:14]};
  assign fx = tx_q[13:0];
  assign fy = ty_q[13:0];
  assign x1 = (x0 + 10'd1 < {1'b0, bw}) ? x0 + 10'd1 : {1'b0, bw} - 10'd1;
  assign y1 = (y0 + 10'd1 < {1'b0, bh}) ? y0 + 10'd1 : {1'b0, bh} - 10'd1;
  assign cpx = (csx[23:14] > 10'({1'b0, bw} - 10'd1)) ? 10'({1'b0, bw} - 10'd1)
                                                        : 10'(csx[23:14]);
  assign cpy = (csy[23:14] > 10'({1'b0, bh} - 10'd1)) ? 10'({1'b0, bh} - 10'd1)
                                                        : 10'(csy[23:14]);

  logic [XW+YW-1:0] raddr;
  always_comb begin
    unique case (ctl_i.corner)
      2'd0:    raddr = addr(x0, y0);
      2'd1:    raddr = addr(x1, y0);
      2'd2:    raddr = addr(x0, y1);
      default: raddr = addr(x1, y1);
    endcase
    if (ctl_i.load) raddr = addr(cpx, cpy);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && 32'(item_i.pixel_x) < MAP_WIDTH && 32'(item_i.pixel_y) < MAP_HEIGHT)
      mem_q[addr({2'b0, item_i.pixel_x}, {2'b0, item_i.pixel_y})] <= item_i.pixel_value;
    rd_q <= mem_q[raddr];
  end

  // next step position and checks; ddx,ddy are k*dir, the squares are taken
  // in the check cycle from the step magnitudes
  logic signed [23:0] ndx, ndy, ntx, nty, xmax, ymax;
  assign ndx  = ddx_q + dx_q;
  assign ndy  = ddy_q + dy_q;
  assign ntx  = cx_q + ndx;
  assign nty  = cy_q + ndy;
  assign xmax = 24'({1'b0, bw} - 10'd1) <<< Frac;
  assign ymax = 24'({1'b0, bh} - 10'd1) <<< Frac;

  logic [21:0] adx, ady;
  logic [43:0] sqx, sqy;
  assign adx = 22'(ndx[23] ? -ndx : ndx);
  assign ady = 22'(ndy[23] ? -ndy : ndy);
  assign sqx = 44'(adx) * 44'(adx);
  assign sqy = 44'(ady) * 44'(ady);

  logic [14:0] wx0, wy0;
  assign wx0 = 15'd16384 - {1'b0, fx};
  assign wy0 = 15'd16384 - {1'b0, fy};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cx_q <= cxn; cy_q <= cyn;
      dx_q <= 24'(item_i.dir_x_step);
      dy_q <= 24'(item_i.dir_y_step);
      hsq_q <= 42'(half) * 42'(half);
      ax_q <= cxn; ay_q <= cyn;
      ddx_q <= '0; ddy_q <= '0; k_q <= '0;
    end
    if (ctl_i.save_fwd) begin
      dx_q <= -dx_q; dy_q <= -dy_q;
      ax_q <= cx_q; ay_q <= cy_q;
      ddx_q <= '0; ddy_q <= '0; k_q <= '0;
      last_q <= {seed_q, 28'b0};
      res_o.start_x <= 16'((24'(ax_q) + 24'd32) >> 6);
      res_o.start_y <= 16'((24'(ay_q) + 24'd32) >> 6);
    end
    if (ctl_i.save_bwd) begin
      res_o.end_x <= 16'((24'(ax_q) + 24'd32) >> 6);
      res_o.end_y <= 16'((24'(ay_q) + 24'd32) >> 6);
    end
    if (ctl_i.seed) begin
      last_q <= {rd_q, 28'b0};
      seed_q <= rd_q;
    end
    if (ctl_i.step_calc) begin
      tx_q <= ntx; ty_q <= nty;
      geom_q <= ntx < 0 || ntx > xmax || nty < 0 || nty > ymax
                || (sqx + sqy) > 44'(hsq_q);
    end
    if (ctl_i.lat_corner) p_q[ctl_i.corner - 2'd1] <= rd_q;
    if (ctl_i.mix1) begin
      top_q <= 22'(p_q[0] * wx0) + 22'(p_q[1] * fx);
      bot_q <= 22'(p_q[2] * wx0) + 22'(p_q[3] * fx);
    end
    if (ctl_i.mix2) smp_q <= 36'(top_q * wy0) + 36'(bot_q * fy);
    if (ctl_i.accept) begin
      ax_q <= tx_q; ay_q <= ty_q;
      ddx_q <= ndx; ddy_q <= ndy;
      k_q <= k_q + 8'd1;
      if (mode_i == MODE_RISING) last_q <= smp_q;
    end
  end

  always_comb begin
    sts_o.stop_geom = geom_q;
    sts_o.limit     = (k_q == 8'(StepLimit));
    unique case (mode_i)
      MODE_THRESH: sts_o.stop_edge = smp_q > EdgeLimit;
      MODE_RISING: sts_o.stop_edge = smp_q > last_q;
      default:     sts_o.stop_edge = 1'b0;
    endcase
  end
endmodule

// File: rtl/core/secw_ctrl.sv
// controller of the stroke edge clip walker: sequences seed, steps and the
// two walks; uses secw_pkg
module secw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           query_i,
  input  secw_pkg::sts_t sts_i,
  output secw_pkg::ctl_t ctl_o,
  output logic           busy_o,
  output logic           done_o
);
  import secw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_CHK, S_DEC, S_R0, S_R1, S_R2, S_R3, S_L3,
    S_MIX1, S_MIX2, S_EDGE, S_DONE
  } state_e;

  state_e state_q;
  logic   bwd_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bwd_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (query_i) begin
          state_q <= S_SEED;
          bwd_q   <= 1'b0;
        end
        S_SEED: state_q <= S_CHK;
        S_CHK:  state_q <= S_DEC;
        S_DEC: begin
          if (sts_i.limit || sts_i.stop_geom) begin
            if (bwd_q) begin
              state_q <= S_DONE;
            end else begin
              bwd_q   <= 1'b1;
              state_q <= S_CHK;
            end
          end else begin
            state_q <= S_R0;
          end
        end
        S_R0:   state_q <= S_R1;
        S_R1:   state_q <= S_R2;
        S_R2:   state_q <= S_R3;
        S_R3:   state_q <= S_L3;
        S_L3:   state_q <= S_MIX1;
        S_MIX1: state_q <= S_MIX2;
        S_MIX2: state_q <= S_EDGE;
        S_EDGE: begin
          if (sts_i.stop_edge) begin
            if (bwd_q) begin
              state_q <= S_DONE;
            end else begin
              bwd_q   <= 1'b1;
              state_q <= S_CHK;
            end
          end else begin
            state_q <= S_CHK;
          end
        end
        S_DONE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic walk_end;
  assign walk_end = (state_q == S_DEC && (sts_i.limit || sts_i.stop_geom))
                 || (state_q == S_EDGE && sts_i.stop_edge);

  always_comb begin
    ctl_o = '0;
    ctl_o.load = (state_q == S_IDLE) && query_i;
    ctl_o.seed = (state_q == S_SEED);
    ctl_o.step_calc = (state_q == S_CHK);
    unique case (state_q)
      S_R0: begin ctl_o.rd_corner = 1'b1; ctl_o.corner = 2'd0; end
      S_R1: begin
        ctl_o.rd_corner = 1'b1; ctl_o.corner = 2'd1; ctl_o.lat_corner = 1'b1;
      end
      S_R2: begin
        ctl_o.rd_corner = 1'b1; ctl_o.corner = 2'd2; ctl_o.lat_corner = 1'b1;
      end
      S_R3: begin
        ctl_o.rd_corner = 1'b1; ctl_o.corner = 2'd3; ctl_o.lat_corner = 1'b1;
      end
      S_L3: begin ctl_o.corner = 2'd0; ctl_o.lat_corner = 1'b1; end
      default: ;
    endcase
    ctl_o.mix1 = (state_q == S_MIX1);
    ctl_o.mix2 = (state_q == S_MIX2);
    ctl_o.accept = (state_q == S_EDGE) && !sts_i.stop_edge;
    ctl_o.save_fwd = walk_end && !bwd_q;
    ctl_o.save_bwd = walk_end && bwd_q;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
endmodule

// File: rtl/core/stroke_edge_clip_walker.sv
// stroke edge clip walker, top level: config registers, controller, datapath
// a pixel write never raises busy; a query strobes its result once both walks
// have ended (at most 128 steps each way) and takes the next item in the strobe
// cycle; each step makes four reads on the single map port plus check and mix states
// the receiver cannot stall; async reset clears control and config, not the edge map
module stroke_edge_clip_walker #(
  parameter int unsigned MAP_WIDTH  = 256,
  parameter int unsigned MAP_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  secw_pkg::in_item_t  item_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output secw_pkg::out_item_t res_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [8:0]          cfg_data_i
);
  import secw_pkg::*;

  logic [8:0] width_q, height_q;
  logic [1:0] mode_q;
  ctl_t ctl;
  sts_t sts;
  logic busy, acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      mode_q   <= MODE_THRESH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_MODE:   mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign acc = start_i && !busy;

  secw_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .query_i(acc && item_i.op),
    .sts_i(sts), .ctl_o(ctl), .busy_o(busy), .done_o(res_valid_o)
  );

  secw_datapath #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_dp (
    .clk_i, .item_i,
    .wr_i(acc && !item_i.op),
    .bw_i(width_q), .bh_i(height_q), .mode_i(mode_q),
    .ctl_i(ctl), .sts_o(sts), .res_o
  );

  assign busy_o = busy;
endmodule

// File: rtl/core/secw_checker.sv
// port-level checks for the stroke edge clip walker, bound to the top level
// uses secw_pkg
module secw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic res_valid_o,
  input secw_pkg::in_item_t item_i
);
  import secw_pkg::*;

  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe longer than a cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.op |=> busy_o) else $error("query not taken");

  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !item_i.op |=> !busy_o) else $error("write made busy");

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o && $past(busy_o)) else $error("result without transaction");
endmodule

bind stroke_edge_clip_walker secw_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .res_valid_o, .item_i
);
